### hdl/pmct_pkg.sv
// Shared types and constants for the mouse cursor tracker.
package pmct_pkg;

    localparam int X_W         = 10;
    localparam int X_LIM       = 1000;
    localparam int X_TOP       = 999;
    localparam int X_RESET     = 500;
    localparam int COL_W       = 7;
    localparam int ROW_W       = 5;
    localparam int BTN_W       = 3;
    localparam int DIV_IN_W    = 20;
    localparam int RECIP_W     = 21;
    localparam int DIV_SHIFT   = 30;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 21'd1073742;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        POS_STATUS = 3'b001,
        POS_DX     = 3'b010,
        POS_DY     = 3'b100
    } byte_pos_t;

    typedef struct packed {
        logic [BTN_W-1:0] buttons;
        logic [7:0]       dx;
        logic [7:0]       dy;
    } packet_t;

endpackage

### hdl/pmct_front.sv
// Byte framer that assembles three-byte mouse packets and pushes them to the queue.
module pmct_front
    import pmct_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       q_full,
    output logic       q_push,
    output packet_t    q_data
);

    byte_pos_t         pos_reg, pos_next;
    logic [BTN_W-1:0]  status_reg;
    logic [7:0]        dx_reg;
    logic              take;

    assign s_ready = !((pos_reg == POS_DY) && q_full);
    assign take    = s_valid && s_ready;
    assign q_push  = take && (pos_reg == POS_DY);
    assign q_data  = '{buttons: status_reg, dx: dx_reg, dy: s_rx_byte};

    always_comb begin
        pos_next = pos_reg;
        if (take) begin
            case (pos_reg)
                POS_STATUS: pos_next = POS_DX;
                POS_DX:     pos_next = POS_DY;
                POS_DY:     pos_next = POS_STATUS;
                default:    pos_next = POS_STATUS;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_STATUS;
        end else begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && (pos_reg == POS_STATUS)) begin
            status_reg <= s_rx_byte[BTN_W-1:0];
        end
        if (take && (pos_reg == POS_DX)) begin
            dx_reg <= s_rx_byte;
        end
    end

endmodule

### hdl/pmct_fifo.sv
// Short packet queue between the framer and the cursor update pipeline.
module pmct_fifo
    import pmct_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  packet_t push_data,
    output logic    full,
    input  logic    pop,
    output packet_t pop_data,
    output logic    empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    packet_t          mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW:0]      count_reg, count_next;

    assign full     = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hdl/pmct_back.sv
// Cursor update pipeline: position update and clamp, scaling, cell division, result word.
module pmct_back
    import pmct_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_empty,
    input  packet_t          q_data,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [COL_W-1:0] m_old_col,
    output logic [ROW_W-1:0] m_old_row,
    output logic [COL_W-1:0] m_new_col,
    output logic [ROW_W-1:0] m_new_row,
    output logic [BTN_W-1:0] m_button_bits
);

    localparam int Y_LIM   = 1000 * ROWS;
    localparam int Y_TOP   = 999 * ROWS;
    localparam int Y_RESET = 500 * ROWS;
    localparam int YW      = $clog2(Y_LIM);
    localparam int SW      = ((YW > 16) ? YW : 16) + 2;
    localparam int SXW     = X_W + 2;
    localparam int PROD_W  = DIV_IN_W + RECIP_W;
    localparam int RST_COL_I = (X_RESET * COLS) / 1000;
    localparam int RST_ROW_I = Y_RESET / 1000;
    localparam logic [COL_W-1:0] RST_COL = RST_COL_I[COL_W-1:0];
    localparam logic [ROW_W-1:0] RST_ROW = RST_ROW_I[ROW_W-1:0];

    logic [X_W-1:0]       x_pos_reg, x_pos_next;
    logic [YW-1:0]        y_pos_reg, y_pos_next;
    logic signed [SXW-1:0] nx_s;
    logic signed [SW-1:0]  ny_s;
    logic                 adv;

    logic                 v1_reg, v2_reg, v3_reg;
    logic [BTN_W-1:0]     btn1_reg, btn2_reg, btn3_reg;
    logic [X_W-1:0]       x1_reg;
    logic [YW-1:0]        y1_reg;
    logic [DIV_IN_W-1:0]  px2_reg, y2_reg;
    logic [PROD_W-1:0]    col_prod, row_prod;
    logic [COL_W-1:0]     col_next;
    logic [ROW_W-1:0]     row_next;
    logic [COL_W-1:0]     ncol3_reg, ocol3_reg, last_col_reg;
    logic [ROW_W-1:0]     nrow3_reg, orow3_reg, last_row_reg;

    assign adv   = !(v3_reg && !m_ready);
    assign q_pop = adv && !q_empty;

    always_comb begin
        nx_s = $signed({2'b00, x_pos_reg}) + $signed({{(SXW-8){q_data.dx[7]}}, q_data.dx});
        if (nx_s[SXW-1]) begin
            x_pos_next = '0;
        end else if (nx_s[X_W:0] >= (X_W+1)'(X_LIM)) begin
            x_pos_next = X_W'(X_TOP);
        end else begin
            x_pos_next = nx_s[X_W-1:0];
        end

        ny_s = $signed(SW'(y_pos_reg))
             - $signed(SW'(COLS)) * $signed({{(SW-8){q_data.dy[7]}}, q_data.dy});
        if (ny_s[SW-1]) begin
            y_pos_next = '0;
        end else if ($unsigned(ny_s) >= SW'(Y_LIM)) begin
            y_pos_next = YW'(Y_TOP);
        end else begin
            y_pos_next = ny_s[YW-1:0];
        end
    end

    assign col_prod = PROD_W'(px2_reg) * PROD_W'(RECIP_1000);
    assign row_prod = PROD_W'(y2_reg) * PROD_W'(RECIP_1000);
    assign col_next = col_prod[DIV_SHIFT+COL_W-1:DIV_SHIFT];
    assign row_next = row_prod[DIV_SHIFT+ROW_W-1:DIV_SHIFT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_pos_reg    <= X_W'(X_RESET);
            y_pos_reg    <= YW'(Y_RESET);
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            last_col_reg <= RST_COL;
            last_row_reg <= RST_ROW;
        end else if (adv) begin
            v1_reg <= !q_empty;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (!q_empty) begin
                x_pos_reg <= x_pos_next;
                y_pos_reg <= y_pos_next;
            end
            if (v2_reg) begin
                last_col_reg <= col_next;
                last_row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            btn1_reg  <= q_data.buttons;
            x1_reg    <= x_pos_next;
            y1_reg    <= y_pos_next;
            btn2_reg  <= btn1_reg;
            px2_reg   <= DIV_IN_W'(x1_reg) * DIV_IN_W'(COLS);
            y2_reg    <= DIV_IN_W'(y1_reg);
            btn3_reg  <= btn2_reg;
            ncol3_reg <= col_next;
            nrow3_reg <= row_next;
            ocol3_reg <= last_col_reg;
            orow3_reg <= last_row_reg;
        end
    end

    assign m_valid       = v3_reg;
    assign m_old_col     = ocol3_reg;
    assign m_old_row     = orow3_reg;
    assign m_new_col     = ncol3_reg;
    assign m_new_row     = nrow3_reg;
    assign m_button_bits = btn3_reg;

endmodule

### hdl/ps2_mouse_cursor_tracker_unit.sv
// Each packet's result word passes through the queue and the update pipeline registers.
// Throughput: one byte per cycle unless the queue is full; the position update is combinational.
// A two-entry packet queue separates the byte framer from the update pipeline.
// Reset (aresetn, synchronous, active low) restarts framing at the status byte
// and returns the cursor to the screen center.
module ps2_mouse_cursor_tracker_unit
    import pmct_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_rx_byte,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [COL_W-1:0] m_old_col,
    output logic [ROW_W-1:0] m_old_row,
    output logic [COL_W-1:0] m_new_col,
    output logic [ROW_W-1:0] m_new_row,
    output logic [BTN_W-1:0] m_button_bits
);

    logic    q_full, q_push, q_pop, q_empty;
    packet_t q_in, q_out;

    pmct_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    pmct_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    pmct_back #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_data        (q_out),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_old_col     (m_old_col),
        .m_old_row     (m_old_row),
        .m_new_col     (m_new_col),
        .m_new_row     (m_new_row),
        .m_button_bits (m_button_bits)
    );

endmodule

### tb/tb_ps2_mouse_cursor_tracker_unit.sv
// Self-checking testbench for the PS/2 mouse cursor tracker: packet table, then random bytes.
module tb_ps2_mouse_cursor_tracker_unit
    import pmct_pkg::*;
();

    localparam int COLS        = 80;
    localparam int ROWS        = 25;
    localparam int RAND_PACKETS = 283;
    localparam int QUIET_TAIL  = 40;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DIR_ROWS    = 8;

    typedef struct packed {
        logic [COL_W-1:0] old_col;
        logic [ROW_W-1:0] old_row;
        logic [COL_W-1:0] new_col;
        logic [ROW_W-1:0] new_row;
        logic [BTN_W-1:0] buttons;
    } cell_move_t;

    typedef struct packed {
        logic [7:0] status;
        logic [7:0] dx;
        logic [7:0] dy;
        logic       pinned;
        cell_move_t fixed_move;
    } packet_row_t;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [7:0]       s_rx_byte;
    logic             m_valid;
    logic             m_ready;
    logic [COL_W-1:0] m_old_col;
    logic [ROW_W-1:0] m_old_row;
    logic [COL_W-1:0] m_new_col;
    logic [ROW_W-1:0] m_new_row;
    logic [BTN_W-1:0] m_button_bits;

    cell_move_t  cell_moves_q[$];
    packet_row_t packet_table[DIR_ROWS];
    bit          quiet;
    bit          pin_armed;
    cell_move_t  pin_move;
    int          fail_count;
    int          cycle_count;

    logic [1:0]  trk_pos;
    logic [7:0]  trk_status;
    logic [7:0]  trk_dx;
    int          trk_x;
    int          trk_y;

    ps2_mouse_cursor_tracker_unit #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_old_col    (m_old_col),
        .m_old_row    (m_old_row),
        .m_new_col    (m_new_col),
        .m_new_row    (m_new_row),
        .m_button_bits(m_button_bits)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    function automatic logic [COL_W-1:0] col_of(int x);
        int c;
        c = (x * COLS) / 1000;
        return c[COL_W-1:0];
    endfunction

    function automatic logic [ROW_W-1:0] row_of(int y);
        int r;
        r = y / 1000;
        return r[ROW_W-1:0];
    endfunction

    task automatic track_cursor(input logic [7:0] b, output bit done, output cell_move_t mv);
        int nx;
        int ny;
        done = 1'b0;
        mv = '0;
        if (trk_pos == 2'd0) begin
            trk_status = b;
            trk_pos = 2'd1;
        end else if (trk_pos == 2'd1) begin
            trk_dx = b;
            trk_pos = 2'd2;
        end else begin
            trk_pos = 2'd0;
            mv.old_col = col_of(trk_x);
            mv.old_row = row_of(trk_y);
            nx = trk_x + int'($signed(trk_dx));
            ny = trk_y - COLS * int'($signed(b));
            if (nx < 0) nx = 0;
            if (nx >= 1000) nx = 999;
            if (ny < 0) ny = 0;
            if (ny >= 1000 * ROWS) ny = 999 * ROWS;
            trk_x = nx;
            trk_y = ny;
            mv.new_col = col_of(trk_x);
            mv.new_row = row_of(trk_y);
            mv.buttons = trk_status[BTN_W-1:0];
            done = 1'b1;
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        cell_move_t want;
        cell_move_t mv;
        bit done;
        if (aresetn && m_valid && m_ready) begin
            if (cell_moves_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %0d %0d %0d %0d %0d",
                         $time, m_old_col, m_old_row, m_new_col, m_new_row, m_button_bits);
                fail_count++;
            end else begin
                want = cell_moves_q.pop_front();
                check_field("old_col", want.old_col, m_old_col);
                check_field("old_row", want.old_row, m_old_row);
                check_field("new_col", want.new_col, m_new_col);
                check_field("new_row", want.new_row, m_new_row);
                check_field("button_bits", want.buttons, m_button_bits);
            end
        end
        if (aresetn && s_valid && s_ready) begin
            track_cursor(s_rx_byte, done, mv);
            if (done) begin
                if (pin_armed) begin
                    mv = pin_move;
                    pin_armed = 1'b0;
                end
                cell_moves_q.push_back(mv);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_ps2_mouse_cursor_tracker_unit failed");
            $finish;
        end
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!quiet && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit pin, input cell_move_t mv);
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        if (pin) begin
            pin_move = mv;
            pin_armed = 1'b1;
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic logic [7:0] pick_delta();
        logic [7:0] edges[6] = '{8'h7F, 8'h80, 8'h81, 8'hFF, 8'h00, 8'h01};
        case ($urandom_range(0, 3))
            0, 1: return 8'($urandom_range(0, 255));
            2: return 8'($signed($urandom_range(0, 16)) - 8);
            default: return edges[$urandom_range(0, 5)];
        endcase
    endfunction

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_rx_byte = 8'h00;
        quiet = 1'b0;
        pin_armed = 1'b0;
        pin_move = '0;
        fail_count = 0;
        cycle_count = 0;
        trk_pos = 2'd0;
        trk_status = 8'h00;
        trk_dx = 8'h00;
        trk_x = X_RESET;
        trk_y = 500 * ROWS;

        // The first row is taken from the reset center; the sixth sits at the top clamp.
        packet_table = '{
            '{8'h07, 8'h00, 8'h00, 1'b1, '{7'd40, 5'd12, 7'd40, 5'd12, 3'd7}},
            '{8'h00, 8'h7F, 8'h80, 1'b0, '0},
            '{8'hFF, 8'h7F, 8'h80, 1'b0, '0},
            '{8'h08, 8'h7F, 8'h80, 1'b0, '0},
            '{8'h05, 8'h7F, 8'h80, 1'b0, '0},
            '{8'h02, 8'h7F, 8'h80, 1'b1, '{7'd79, 5'd24, 7'd79, 5'd24, 3'd2}},
            '{8'h01, 8'h80, 8'h7F, 1'b0, '0},
            '{8'hF8, 8'h80, 8'h7F, 1'b0, '0}
        };

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (packet_table[i]) begin
            send_byte(packet_table[i].status, 1'b0, '0);
            send_byte(packet_table[i].dx, 1'b0, '0);
            send_byte(packet_table[i].dy, packet_table[i].pinned, packet_table[i].fixed_move);
        end

        for (int p = 0; p < RAND_PACKETS; p++) begin
            if (p >= RAND_PACKETS - QUIET_TAIL) quiet = 1'b1;
            send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
            send_byte(pick_delta(), 1'b0, '0);
            send_byte(pick_delta(), 1'b0, '0);
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        while (cell_moves_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (fail_count == 0 && cell_moves_q.size() == 0) begin
            $display("tb_ps2_mouse_cursor_tracker_unit passed");
        end else begin
            $display("tb_ps2_mouse_cursor_tracker_unit failed");
        end
        $finish;
    end

endmodule
